/* sv/sssp_pkg.sv */
// ---------------------------------------------------------------------------
// sssp_pkg
// Shared types and constants for the dense-matrix shortest path engine.
// ---------------------------------------------------------------------------
package sssp_pkg;
   localparam int MaxVertices = 64;
   localparam int VxW  = $clog2(MaxVertices);       // vertex index bits
   localparam int AdrW = 2 * VxW;                   // matrix address bits
   localparam int DistW = 20;
   localparam logic [DistW-1:0] Unreach = 20'hfffff;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_RUN   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [1:0] REG_NUM = 2'd0;
   localparam logic [1:0] REG_SRC = 2'd1;
   localparam logic [1:0] REG_TGT = 2'd2;

   // matrix write request from the sequencer
   typedef struct packed {
      logic             we;
      logic [AdrW-1:0]  addr;
      logic [DistW-1:0] data;
   } mat_wr_type;
endpackage

/* sv/single_source_shortest_path.sv */
// ---------------------------------------------------------------------------
// single_source_shortest_path
// Dijkstra over a dense adjacency matrix, driven by a small sequencer.
// ---------------------------------------------------------------------------
// channel | dir | ports    | contents
// req     | in  | req_*    | operation, vertex_a, vertex_b, weight
// rsp     | out | rsp_*    | distance, reachable (one per run)
// csr     | in  | csr_*    | num_vertices, source_vertex, target_vertex
//
// load: one matrix write per direction. clear: sweeps every matrix word, one a
// cycle; the same sweep runs after reset, req_tready low meanwhile.
// run: an init pass copying the source row, then n-1 rounds, each a scan pass
// then a relax pass over the single matrix and distance ports.
// a finished result waits in rsp until taken; req_tready stays low until then.
// ---------------------------------------------------------------------------
module single_source_shortest_path
   import sssp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] operation, [8:2] vertex_a, [15:9] vertex_b, [31:16] weight
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [19:0] distance, [20] reachable, [23:21] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   typedef enum logic [9:0] {
      ST_CLR   = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_LOAD2 = 10'b0000000100,
      ST_INIT  = 10'b0000001000,
      ST_SCAN  = 10'b0000010000,
      ST_MARK  = 10'b0000100000,
      ST_RELAX = 10'b0001000000,
      ST_NEXT  = 10'b0010000000,
      ST_FETCH = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   localparam int CntW = VxW + 1;

   state_type        state_ff, state_in;
   logic [6:0]       num_ff, num_in, src_ff, src_in, tgt_ff, tgt_in;
   logic [AdrW:0]    clr_ff, clr_in;
   logic [CntW-1:0]  i_ff, i_in;        // pass counter (issue side)
   logic [CntW-1:0]  round_ff, round_in;
   logic [VxW-1:0]   k_ff, k_in;        // index of data returning this cycle
   logic             kv_ff, kv_in;      // returning data valid
   logic [VxW-1:0]   u_ff, u_in;
   logic [DistW-1:0] best_ff, best_in, du_ff, du_in;
   logic [MaxVertices-1:0] vis_ff, vis_in;
   logic [VxW-1:0]   lb_a_ff, lb_a_in, lb_b_ff, lb_b_in;
   logic [15:0]      lb_w_ff, lb_w_in;
   logic             rv_ff, rv_in;
   logic [DistW-1:0] rd_ff, rd_in;
   logic             bad_ff, bad_in;

   mat_wr_type       mwr;
   logic [AdrW-1:0]  mrd_addr;
   logic [DistW-1:0] mrd_data;
   logic             dwe;
   logic [VxW-1:0]   dwa, dra;
   logic [DistW-1:0] dwd, drd;

   logic [1:0]       op;
   logic [6:0]       va, vb;
   logic [CntW-1:0]  n_eff;
   logic [VxW-1:0]   s_idx, t_idx;
   logic [DistW:0]   sum;
   logic             take;

   sssp_mat u_mat (
      .clock(clock), .wr(mwr), .rd_addr(mrd_addr), .rd_data(mrd_data)
   );
   sssp_dist u_dist (
      .clock(clock), .we(dwe), .wr_addr(dwa), .wr_data(dwd),
      .rd_addr(dra), .rd_data(drd)
   );

   assign op = req_tdata[1:0];
   assign va = req_tdata[8:2];
   assign vb = req_tdata[15:9];

   always_comb begin
      if (num_ff == 7'd0) begin
         n_eff = CntW'(1);
      end else if (num_ff > 7'(MaxVertices)) begin
         n_eff = CntW'(MaxVertices);
      end else begin
         n_eff = CntW'(num_ff);
      end
   end
   assign s_idx = VxW'(src_ff - 7'd1);
   assign t_idx = VxW'(tgt_ff - 7'd1);
   assign sum   = {1'b0, du_ff} + {1'b0, mrd_data};

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {3'd0, (rd_ff != Unreach), rd_ff};

   always_comb begin
      state_in = state_ff;
      num_in = num_ff; src_in = src_ff; tgt_in = tgt_ff;
      clr_in = clr_ff; i_in = i_ff; round_in = round_ff;
      k_in = k_ff; kv_in = 1'b0; u_in = u_ff; best_in = best_ff; du_in = du_ff;
      vis_in = vis_ff;
      lb_a_in = lb_a_ff; lb_b_in = lb_b_ff; lb_w_in = lb_w_ff;
      rv_in = rv_ff; rd_in = rd_ff; bad_in = bad_ff;
      mwr = '0; mrd_addr = '0;
      dwe = 1'b0; dwa = '0; dwd = '0; dra = '0;

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      if (csr_we) begin
         unique case (csr_index)
            REG_NUM: num_in = csr_wdata;
            REG_SRC: src_in = csr_wdata;
            REG_TGT: tgt_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLR: begin
            mwr.we   = 1'b1;
            mwr.addr = clr_ff[AdrW-1:0];
            mwr.data = (clr_ff[AdrW-1:VxW] == clr_ff[VxW-1:0]) ? '0 : Unreach;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff[AdrW-1:0] == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               case (op)
                  OP_CLEAR: begin
                     clr_in = '0;
                     state_in = ST_CLR;
                  end
                  OP_LOAD: begin
                     if (va >= 7'd1 && va <= 7'(MaxVertices) &&
                         vb >= 7'd1 && vb <= 7'(MaxVertices)) begin
                        lb_a_in = VxW'(va - 7'd1);
                        lb_b_in = VxW'(vb - 7'd1);
                        lb_w_in = req_tdata[31:16];
                        state_in = ST_LOAD2;
                     end
                  end
                  OP_RUN: begin
                     bad_in = (src_ff < 7'd1) || (CntW'(src_ff) > n_eff) ||
                              (tgt_ff < 7'd1) || (CntW'(tgt_ff) > n_eff);
                     i_in = '0;
                     state_in = ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD2: begin
            mwr.we = 1'b1;
            mwr.addr = {lb_a_ff, lb_b_ff};
            mwr.data = DistW'(lb_w_ff);
            if (i_ff == '0) begin
               i_in = CntW'(1);
            end else begin
               mwr.addr = {lb_b_ff, lb_a_ff};
               i_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            // copy source row into distances, one entry a cycle; a bad source or target answers unreachable instead
            if (bad_ff) begin
               rd_in = Unreach;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               if (i_ff < n_eff) begin
                  mrd_addr = {s_idx, i_ff[VxW-1:0]};
                  k_in = i_ff[VxW-1:0];
                  kv_in = 1'b1;
                  i_in = i_ff + 1'b1;
               end
               if (kv_ff) begin
                  dwe = 1'b1;
                  dwa = k_ff;
                  dwd = (k_ff == s_idx) ? '0 : mrd_data;
               end
               vis_in = '0;
               vis_in[s_idx] = 1'b1;
               if (i_ff >= n_eff && !kv_ff) begin
                  round_in = CntW'(1);
                  i_in = '0;
                  best_in = Unreach;
                  u_in = s_idx;
                  state_in = (n_eff == CntW'(1)) ? ST_FETCH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (i_ff < n_eff) begin
               dra = i_ff[VxW-1:0];
               k_in = i_ff[VxW-1:0];
               kv_in = 1'b1;
               i_in = i_ff + 1'b1;
            end
            if (kv_ff && !vis_ff[k_ff] && drd < best_ff) begin
               best_in = drd;
               u_in = k_ff;
            end
            if (i_ff >= n_eff && !kv_ff) begin
               dra = u_ff;
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            vis_in[u_ff] = 1'b1;
            du_in = drd;
            i_in = '0;
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            // matrix row and distance read in step, compare on return
            if (i_ff < n_eff) begin
               mrd_addr = {u_ff, i_ff[VxW-1:0]};
               dra = i_ff[VxW-1:0];
               k_in = i_ff[VxW-1:0];
               kv_in = 1'b1;
               i_in = i_ff + 1'b1;
            end
            if (kv_ff && !vis_ff[k_ff] && mrd_data < Unreach &&
                sum < {1'b0, drd}) begin
               dwe = 1'b1;
               dwa = k_ff;
               dwd = sum[DistW-1:0];
            end
            if (i_ff >= n_eff && !kv_ff) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            i_in = '0;
            best_in = Unreach;
            u_in = s_idx;
            round_in = round_ff + 1'b1;
            state_in = (round_ff + 1'b1 >= n_eff) ? ST_FETCH : ST_SCAN;
         end
         ST_FETCH: begin
            dra = t_idx;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            dra = t_idx;
            rd_in = drd;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         num_ff <= 7'd64; src_ff <= 7'd1; tgt_ff <= 7'd64;
         clr_ff <= '0; i_ff <= '0; round_ff <= '0; kv_ff <= 1'b0;
         rv_ff <= 1'b0; bad_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         num_ff <= num_in; src_ff <= src_in; tgt_ff <= tgt_in;
         clr_ff <= clr_in; i_ff <= i_in; round_ff <= round_in; kv_ff <= kv_in;
         rv_ff <= rv_in; bad_ff <= bad_in;
      end
      k_ff <= k_in; u_ff <= u_in; best_ff <= best_in; du_ff <= du_in;
      vis_ff <= vis_in; lb_a_ff <= lb_a_in; lb_b_ff <= lb_b_in;
      lb_w_ff <= lb_w_in; rd_ff <= rd_in;
   end
endmodule

/* sv/sssp_mat.sv */
// ---------------------------------------------------------------------------
// sssp_mat
// Adjacency matrix memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sssp_mat
   import sssp_pkg::*;
(
   input  logic             clock,
   input  mat_wr_type       wr,
   input  logic [AdrW-1:0]  rd_addr,
   output logic [DistW-1:0] rd_data
);
   logic [DistW-1:0] mem [MaxVertices*MaxVertices];
   logic [DistW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/sssp_dist.sv */
// ---------------------------------------------------------------------------
// sssp_dist
// Per-vertex distance memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sssp_dist
   import sssp_pkg::*;
(
   input  logic             clock,
   input  logic             we,
   input  logic [VxW-1:0]   wr_addr,
   input  logic [DistW-1:0] wr_data,
   input  logic [VxW-1:0]   rd_addr,
   output logic [DistW-1:0] rd_data
);
   logic [DistW-1:0] mem [MaxVertices];
   logic [DistW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
